// ----- hdl/wgsv_pkg.sv -----
// Shared types and constants for the waveguide string voice
`timescale 1ns / 1ps
package wgsv_pkg;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int COEF_SHIFT = 15;
	localparam int GAIN_OFFSET = 4915;

	typedef enum logic [2:0] {
		REG_DELAY_LENGTH = 3'd0,
		REG_DELAY_FRACTION = 3'd1,
		REG_REFLECTION = 3'd2,
		REG_NUT_SIGN = 3'd3,
		REG_STIFFNESS = 3'd4,
		REG_EXCITE_POSITION = 3'd5,
		REG_IMPULSE_SOLO = 3'd6,
		REG_VELOCITY = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_TAPS,
		ST_WAIT_TAPS,
		ST_INJECT,
		ST_RD_NUT,
		ST_WAIT_NUT,
		ST_REFLECT,
		ST_RD_AP,
		ST_WAIT_AP,
		ST_AP_MUL,
		ST_AP_WR,
		ST_RD_R2,
		ST_WAIT_R2,
		ST_INT_MUL_L,
		ST_INT_MUL_R,
		ST_INT_WR,
		ST_GAIN_MUL,
		ST_OUT_MUL,
		ST_ENV_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] mallet_sample;
		logic        mallet_active;
		logic [15:0] envelope_gain;
	} tick_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] mallet_sample;
		logic        mallet_active;
		logic [15:0] envelope_gain;
	} voice_word_t;
endpackage

// ----- hdl/wgsv_stream_if.sv -----
// Valid/ready channel carrying a payload of parameterized type
`timescale 1ns / 1ps
interface wgsv_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/waveguide_string_voice_unit.sv -----
// Top level of the waveguide string voice: sequencer, delay line memories and datapath
//
// channel   | direction | payload
// in_ch     | sink      | mode, mallet_sample, mallet_active, envelope_gain
// out_ch    | source    | sample_out
// cfg_*     | write     | cfg_we, cfg_index, cfg_data
//
// A tick steps through its states in order and presents its result on leaving the
// emit state; the next word is taken back in idle: reads, multiplies and write-backs
// share the single read and write port of each line memory. A pluck stays in idle.
// Reset loads the configuration defaults and clears the state, pointers and output
// register; the line memories are zeroed by a sweep after reset, during which no
// word is accepted. A result waits in the output register; the next word is
// accepted meanwhile, and its tick stalls before emitting until the result is taken.
`timescale 1ns / 1ps
module waveguide_string_voice_unit #(
	parameter int LINE_DEPTH = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [wgsv_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [wgsv_pkg::CFG_DATA_BITS-1:0] cfg_data,
	wgsv_stream_if.sink in_ch,
	wgsv_stream_if.source out_ch
);
	import wgsv_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int SB = SAMPLE_BITS;
	localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

	// configuration
	logic [9:0]  delay_length_q, excite_position_q;
	logic [14:0] delay_fraction_q, velocity_q;
	logic signed [15:0] reflection_q, stiffness_q;
	logic nut_sign_q, impulse_solo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= 10'd100;
			delay_fraction_q <= '0;
			reflection_q <= 16'sd31130;
			nut_sign_q <= 1'b0;
			stiffness_q <= '0;
			excite_position_q <= 10'd3;
			impulse_solo_q <= 1'b0;
			velocity_q <= 15'd26214;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DELAY_LENGTH: delay_length_q <= cfg_data[9:0];
				REG_DELAY_FRACTION: delay_fraction_q <= cfg_data[14:0];
				REG_REFLECTION: reflection_q <= cfg_data;
				REG_NUT_SIGN: nut_sign_q <= cfg_data[0];
				REG_STIFFNESS: stiffness_q <= cfg_data;
				REG_EXCITE_POSITION: excite_position_q <= cfg_data[9:0];
				REG_IMPULSE_SOLO: impulse_solo_q <= cfg_data[0];
				REG_VELOCITY: velocity_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [SB-1:0] sat(input logic signed [63:0] v);
		if (v > 64'(SMAX)) return SMAX;
		if (v < 64'(SMIN)) return SMIN;
		return v[SB-1:0];
	endfunction

	function automatic logic signed [63:0] rnd15(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd16384;
		return t >>> COEF_SHIFT;
	endfunction

	// effective length: clamp to 1 .. LINE_DEPTH-1
	logic [15:0] d_len;
	always_comb begin
		d_len = {6'd0, delay_length_q};
		if (d_len < 16'd1) d_len = 16'd1;
		if (32'(d_len) > LINE_DEPTH - 1) d_len = 16'(LINE_DEPTH - 1);
	end

	function automatic logic [15:0] nextp(input logic [15:0] p, input logic [15:0] d);
		return (p + 16'd1 > d) ? 16'd0 : p + 16'd1;
	endfunction

	function automatic logic [AW-1:0] idx(input logic [15:0] p);
		return (32'(p) < LINE_DEPTH) ? p[AW-1:0] : '0;
	endfunction

	// pointers
	logic [15:0] lt_q, rt_q, br_q, nu_q;

	// memories
	logic signed [SB-1:0] left_mem [LINE_DEPTH];
	logic signed [SB-1:0] right_mem [LINE_DEPTH];
	logic [AW-1:0] l_raddr, r_raddr, l_waddr, r_waddr;
	logic l_we, r_we;
	logic signed [SB-1:0] l_wdata, r_wdata, l_rdata_q, r_rdata_q;

	always_ff @(posedge clk) begin
		if (l_we) left_mem[l_waddr] <= l_wdata;
		if (r_we) right_mem[r_waddr] <= r_wdata;
		l_rdata_q <= left_mem[l_raddr];
		r_rdata_q <= right_mem[r_raddr];
	end

	// clearing sweep
	logic [AW:0] clr_q;
	logic clr_busy;
	assign clr_busy = !clr_q[AW];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clr_busy) clr_q <= clr_q + 1'b1;
	end

	state_t state_q, state_d;
	tick_t tick_q;
	logic signed [SB-1:0] lt_v_q, rt_v_q, l2_v_q, r2_v_q, nu_l_q, nu_r_q;
	logic signed [SB-1:0] lt_new_q, rt_new_q;
	logic signed [SB-1:0] mo_q;
	logic signed [47:0] prod_q, prod2_q;
	logic signed [47:0] gf_q;
	logic signed [SB+1:0] y_q;
	logic signed [SB-1:0] out_q;
	logic out_valid_q;

	logic [AW-1:0] a_lt, a_rt, a_l2, a_r2, a_br, a_nu;
	assign a_lt = idx(lt_q);
	assign a_rt = idx(rt_q);
	assign a_l2 = idx(nextp(lt_q, d_len));
	assign a_r2 = idx(nextp(rt_q, d_len));
	assign a_br = idx(br_q);
	assign a_nu = idx(nu_q);

	logic accept;
	assign in_ch.ready = (state_q == ST_IDLE) && !clr_busy;
	assign accept = in_ch.valid && in_ch.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && !in_ch.payload.mode) state_d = ST_RD_TAPS;
			ST_RD_TAPS: state_d = ST_WAIT_TAPS;
			ST_WAIT_TAPS: state_d = ST_INJECT;
			ST_INJECT: state_d = ST_RD_NUT;
			ST_RD_NUT: state_d = ST_WAIT_NUT;
			ST_WAIT_NUT: state_d = ST_REFLECT;
			ST_REFLECT: state_d = ST_RD_AP;
			ST_RD_AP: state_d = ST_WAIT_AP;
			ST_WAIT_AP: state_d = ST_AP_MUL;
			ST_AP_MUL: state_d = ST_AP_WR;
			ST_AP_WR: state_d = ST_RD_R2;
			ST_RD_R2: state_d = ST_WAIT_R2;
			ST_WAIT_R2: state_d = ST_INT_MUL_L;
			ST_INT_MUL_L: state_d = ST_INT_MUL_R;
			ST_INT_MUL_R: state_d = ST_INT_WR;
			ST_INT_WR: state_d = ST_GAIN_MUL;
			ST_GAIN_MUL: state_d = ST_OUT_MUL;
			ST_OUT_MUL: state_d = ST_ENV_MUL;
			ST_ENV_MUL: state_d = ST_EMIT;
			ST_EMIT: if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	logic signed [63:0] refl_w, ap_w, lt_inj, rt_inj;
	logic signed [SB-1:0] refl_r, refl_src;
	always_comb begin
		l_raddr = a_lt; r_raddr = a_rt;
		l_we = 1'b0; r_we = 1'b0;
		l_waddr = a_lt; r_waddr = a_rt;
		l_wdata = '0; r_wdata = '0;
		lt_inj = 64'(lt_v_q) + 64'(signed'(tick_q.mallet_sample));
		rt_inj = 64'(rt_v_q) + 64'(signed'(tick_q.mallet_sample));
		refl_r = nut_sign_q ? nu_l_q : sat(-64'(nu_l_q));
		// the bridge gain sees the right line after its nut write
		refl_src = (a_br == a_nu) ? refl_r : nu_r_q;
		refl_w = 64'(32'(reflection_q) * 32'(refl_src));
		ap_w = 64'(lt_v_q) + rnd15(64'(prod_q));
		if (clr_busy) begin
			l_we = 1'b1; r_we = 1'b1;
			l_waddr = clr_q[AW-1:0]; r_waddr = clr_q[AW-1:0];
		end else begin
			case (state_q)
				ST_INJECT: if (tick_q.mallet_active) begin
					l_we = 1'b1; r_we = 1'b1;
					l_wdata = sat(lt_inj); r_wdata = sat(rt_inj);
				end
				ST_RD_NUT: begin
					l_raddr = a_nu; r_raddr = a_nu;
				end
				ST_REFLECT: begin
					// right[br] from left[nu]; left[br] from right[nu] after that write
					r_we = 1'b1; r_waddr = a_br;
					r_wdata = refl_r;
					l_we = 1'b1; l_waddr = a_br;
					l_wdata = sat(rnd15(refl_w));
				end
				ST_RD_AP: begin
					l_raddr = a_l2; r_raddr = a_r2;
				end
				ST_AP_WR: begin
					l_we = 1'b1; l_waddr = a_l2; l_wdata = sat(ap_w);
				end
				ST_RD_R2: begin
					l_raddr = a_lt; r_raddr = a_r2;
				end
				ST_INT_WR: begin
					l_we = 1'b1; r_we = 1'b1;
					l_wdata = lt_new_q; r_wdata = sat(rnd15(64'(prod2_q)));
				end
				default: ;
			endcase
		end
	end

	logic signed [16:0] frac;
	logic signed [16:0] gain;
	assign frac = 17'sd32768 - 17'(delay_fraction_q);
	assign gain = 17'((20'(velocity_q) * 20'd15 + 20'd8) >> 4) + 17'(GAIN_OFFSET);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) tick_q <= '{in_ch.payload.mallet_sample,
				in_ch.payload.mallet_active, in_ch.payload.envelope_gain};
			ST_WAIT_TAPS: begin
				lt_v_q <= l_rdata_q; rt_v_q <= r_rdata_q;
			end
			ST_INJECT: begin
				if (tick_q.mallet_active) begin
					lt_v_q <= sat(lt_inj); rt_v_q <= sat(rt_inj);
					mo_q <= tick_q.mallet_sample;
				end else begin
					mo_q <= '0;
				end
			end
			ST_WAIT_NUT: begin
				nu_l_q <= l_rdata_q; nu_r_q <= r_rdata_q;
			end
			ST_REFLECT: begin
				// forward the reflection writes onto the tap values
				if (a_br == a_lt) lt_v_q <= sat(rnd15(refl_w));
				if (a_br == a_rt) rt_v_q <= refl_r;
			end
			ST_WAIT_AP: begin
				l2_v_q <= l_rdata_q;
			end
			ST_AP_MUL: prod_q <= 48'(stiffness_q) * (48'(l2_v_q) - 48'(lt_v_q));
			ST_AP_WR: l2_v_q <= sat(ap_w);
			ST_WAIT_R2: r2_v_q <= r_rdata_q;
			ST_INT_MUL_L: begin
				prod_q <= 48'(signed'({1'b0, delay_fraction_q})) * 48'(lt_v_q)
					+ 48'(frac) * 48'(l2_v_q);
			end
			ST_INT_MUL_R: begin
				lt_new_q <= sat(rnd15(64'(prod_q)));
				prod2_q <= 48'(signed'({1'b0, delay_fraction_q})) * 48'(rt_v_q)
					+ 48'(frac) * 48'(r2_v_q);
			end
			ST_INT_WR: begin
				rt_new_q <= sat(rnd15(64'(prod2_q)));
				gf_q <= 48'(gain) * 48'(frac);
			end
			ST_GAIN_MUL: gf_q <= 48'(rnd15(64'(gf_q)));
			ST_OUT_MUL: begin
				if (impulse_solo_q) y_q <= (SB+2)'(mo_q);
				else y_q <= (SB+2)'(rnd15(64'(gf_q * (48'(lt_new_q) + 48'(rt_new_q)))));
			end
			ST_ENV_MUL: prod_q <= 48'(y_q) * 48'(signed'({1'b0, tick_q.envelope_gain}));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lt_q <= '0; rt_q <= '0; br_q <= '0; nu_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (accept && in_ch.payload.mode) begin
				lt_q <= (excite_position_q > d_len[9:0] - 10'd1) ?
					d_len - 16'd1 : {6'd0, excite_position_q};
				rt_q <= d_len - ((excite_position_q > d_len[9:0] - 10'd1) ?
					d_len - 16'd1 : {6'd0, excite_position_q});
				br_q <= d_len;
				nu_q <= '0;
			end
			if (state_q == ST_EMIT && (!out_valid_q || out_ch.ready)) begin
				out_q <= sat(rnd15(64'(prod_q)));
				out_valid_q <= 1'b1;
				lt_q <= nextp(lt_q, d_len);
				rt_q <= nextp(rt_q, d_len);
				br_q <= nextp(br_q, d_len);
				nu_q <= nextp(nu_q, d_len);
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ch.ready) else $error("word accepted during clear");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && (!out_valid_q || out_ch.ready)) |=> out_valid_q)
		else $error("result not presented");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (nu_q <= 16'(LINE_DEPTH)))
		else $error("nut pointer out of range");
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the waveguide string voice with a built-in line predictor
`timescale 1ns / 1ps
module testbench;
	import wgsv_pkg::*;

	localparam int DEPTH = 1024;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	wgsv_stream_if #(.payload_t(voice_word_t)) in_ch ();
	wgsv_stream_if #(.payload_t(logic [15:0])) out_ch ();

	waveguide_string_voice_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// predictor copy of registers and lines
	logic [9:0] len_q;
	logic [14:0] frac_q;
	logic signed [15:0] refl_q;
	logic tube_q;
	logic signed [15:0] stiff_q;
	logic [9:0] excite_q;
	logic solo_q;
	logic [14:0] vel_q;
	longint left_wave [DEPTH];
	longint right_wave [DEPTH];
	int unsigned ltap, rtap, bridge, nut;

	voice_word_t pending_words[$];
	logic [15:0] expected_samples[$];
	int mismatches = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit calm = 0;
	int phase = -1;
	int hold_left = 0;
	bit hold_done = 0;

	function automatic longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint rnd15(longint v);
		return (v + 16384) >>> 15;
	endfunction

	function automatic int unsigned wrap_next(int unsigned p, int unsigned d);
		return (p + 1 > d) ? 0 : p + 1;
	endfunction

	// returns 1 when the word produces a sample
	function automatic bit voice_predict(voice_word_t w, output logic [15:0] sample);
		int unsigned d, e, lt, rt, l2, r2, br, nu;
		longint m, mo, df, fr, g, gf, y;
		d = len_q;
		if (d < 1) d = 1;
		if (d > DEPTH - 1) d = DEPTH - 1;
		if (w.mode) begin
			e = excite_q;
			if (e > d - 1) e = d - 1;
			ltap = e;
			rtap = d - e;
			bridge = d;
			nut = 0;
			return 0;
		end
		m = longint'($signed(w.mallet_sample));
		lt = ltap; rt = rtap; br = bridge; nu = nut;
		l2 = wrap_next(ltap, d);
		r2 = wrap_next(rtap, d);
		mo = 0;
		if (w.mallet_active) begin
			left_wave[lt] = sat16(left_wave[lt] + m);
			right_wave[rt] = sat16(right_wave[rt] + m);
			mo = m;
		end
		right_wave[br] = tube_q ? left_wave[nu] : sat16(-left_wave[nu]);
		left_wave[br] = sat16(rnd15(longint'(refl_q) * right_wave[nu]));
		left_wave[l2] = sat16(left_wave[lt] +
			rnd15(longint'(stiff_q) * (left_wave[l2] - left_wave[lt])));
		df = frac_q;
		fr = 32768 - df;
		left_wave[lt] = sat16(rnd15(df * left_wave[lt] + fr * left_wave[l2]));
		right_wave[rt] = sat16(rnd15(df * right_wave[rt] + fr * right_wave[r2]));
		if (solo_q) begin
			y = mo;
		end else begin
			g = ((15 * longint'(vel_q) + 8) >>> 4) + GAIN_OFFSET;
			gf = rnd15(g * fr);
			y = rnd15(gf * (left_wave[lt] + right_wave[rt]));
		end
		y = sat16(rnd15(y * longint'(w.envelope_gain)));
		ltap = wrap_next(ltap, d);
		rtap = wrap_next(rtap, d);
		bridge = wrap_next(bridge, d);
		nut = wrap_next(nut, d);
		sample = y[15:0];
		return 1;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// long receiver hold-off, started once in the fourth phase
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (phase == 3 && !hold_done) begin
			hold_left = LONG_HOLD;
			hold_done = 1;
		end
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		logic [15:0] s;
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.payload <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				if (voice_predict(in_ch.payload, s)) expected_samples.push_back(s);
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 0;
				end else if (pending_words.size() > 0) begin
					in_ch.payload <= pending_words.pop_front();
					in_ch.valid <= 1;
					if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 10);
				end else begin
					in_ch.valid <= 0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected sample %h", out_ch.payload);
				end else begin
					want = expected_samples.pop_front();
					if (out_ch.payload !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sample_out: expected %h, got %h", want, out_ch.payload);
					end
				end
			end
			if (hold_left > 0) begin
				out_ch.ready <= 0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 10);
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	task automatic write_reg(reg_idx_t r, int unsigned v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_data <= v[15:0];
		case (r)
			REG_DELAY_LENGTH: len_q = v[9:0];
			REG_DELAY_FRACTION: frac_q = v[14:0];
			REG_REFLECTION: refl_q = v[15:0];
			REG_NUT_SIGN: tube_q = v[0];
			REG_STIFFNESS: stiff_q = v[15:0];
			REG_EXCITE_POSITION: excite_q = v[9:0];
			REG_IMPULSE_SOLO: solo_q = v[0];
			REG_VELOCITY: vel_q = v[14:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic settle();
		while (pending_words.size() > 0 || in_ch.valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic voice_word_t word(bit mode, int unsigned m, bit act, int unsigned env);
		voice_word_t w;
		w.mode = mode;
		w.mallet_sample = m[15:0];
		w.mallet_active = act;
		w.envelope_gain = env[15:0];
		return w;
	endfunction

	// pluck, strike for a few ticks, then let the string ring
	task automatic queue_note(int ticks);
		int hits;
		hits = $urandom_range(1, 4);
		pending_words.push_back(word(1, $urandom, $urandom, $urandom));
		for (int i = 0; i < ticks; i++)
			pending_words.push_back(word(0, $urandom, i < hits,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(16384, 32768)));
	endtask

	initial begin
		int unsigned lens[8] = '{0, 1, 1023, 2, 7, 30, 5, 12};
		int budget;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		len_q = 100; frac_q = 0; refl_q = 31130; tube_q = 0;
		stiff_q = 0; excite_q = 3; solo_q = 0; vel_q = 26214;
		foreach (left_wave[i]) begin
			left_wave[i] = 0;
			right_wave[i] = 0;
		end
		ltap = 0; rtap = 0; bridge = 0; nut = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		// hold off through the line clearing sweep
		budget = 4 * DEPTH;
		while (!in_ch.ready && budget > 0) begin
			@(posedge clk);
			budget--;
		end

		// directed: tick before pluck, field extremes, nut saturation, big envelope
		pending_words.push_back(word(0, 16'h7fff, 1, 32768));
		pending_words.push_back(word(0, 16'h8000, 1, 65535));
		pending_words.push_back(word(0, 16'h8000, 1, 0));
		pending_words.push_back(word(1, 0, 0, 0));
		pending_words.push_back(word(0, 16'h8000, 1, 32768));
		pending_words.push_back(word(0, 16'h8000, 1, 65535));
		pending_words.push_back(word(0, 16'h7fff, 1, 65535));
		for (int i = 0; i < 8; i++) pending_words.push_back(word(0, 0, 0, 32768));
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 7);
			phase = ph;
			write_reg(REG_DELAY_LENGTH, lens[ph]);
			write_reg(REG_DELAY_FRACTION, (ph == 1) ? 32767 : (ph == 2) ? 0 : $urandom_range(0, 32767));
			write_reg(REG_REFLECTION, (ph == 1) ? 16'h8000 : (ph == 2) ? 16'h7fff : $urandom);
			write_reg(REG_NUT_SIGN, ph % 2);
			write_reg(REG_STIFFNESS, (ph == 3) ? 16'h8000 : (ph == 4) ? 16'h7fff : $urandom);
			write_reg(REG_EXCITE_POSITION, (ph == 2) ? 1022 : (ph == 5) ? 1023 : $urandom_range(0, 40));
			write_reg(REG_IMPULSE_SOLO, ph == 4);
			write_reg(REG_VELOCITY, (ph == 1) ? 0 : (ph == 3) ? 32767 : $urandom_range(0, 32767));
			while (pending_words.size() < 40) begin
				if ($urandom_range(0, 9) == 0)
					pending_words.push_back(word($urandom, $urandom, $urandom, $urandom));
				else
					queue_note($urandom_range(3, 20));
			end
			// length change mid-note leaves pointers beyond the new end
			if (ph == 2) begin
				settle();
				write_reg(REG_DELAY_LENGTH, 4);
				for (int i = 0; i < 8; i++) pending_words.push_back(word(0, $urandom, 1, $urandom));
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/wgsv_pkg.sv
hdl/wgsv_stream_if.sv
hdl/waveguide_string_voice_unit.sv
tb/testbench.sv
